### rtl/biquad_iir_filter_multichannel_top_defines.svh
// Assertion macros shared by the biquad filter RTL.
`ifndef BIQUAD_IIR_FILTER_MULTICHANNEL_TOP_DEFINES_SVH
`define BIQUAD_IIR_FILTER_MULTICHANNEL_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BQF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define BQF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bqf_pkg.sv
// Shared constants and types of the biquad filter.
package bqf_pkg;

  localparam int DEF_CHANNELS    = 8;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DELAY_FRAC      = 8;
  localparam int DELAY_EXTRA     = 12;   // 8 fraction bits + 4 headroom bits
  localparam int COEF_BITS       = 32;
  localparam int COEF_FRAC       = 28;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic [COEF_BITS-1:0] COEF_ONE  = 32'h1000_0000;  // 1.0 in Q3.28
  localparam logic [COEF_BITS-1:0] COEF_ZERO = 32'h0000_0000;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_ctl_t;

endpackage

### rtl/bqf_in_if.sv
// Input channel of the biquad filter: command, channel and sample.
interface bqf_in_if import bqf_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int CH_W        = 3
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [CH_W-1:0]               channel_index;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output command, output channel_index, output sample_in,
                  input ready);
  modport sink (input valid, input command, input channel_index, input sample_in,
                output ready);
endinterface

### rtl/bqf_out_if.sv
// Output channel of the biquad filter: filtered sample, channel and clip flag.
interface bqf_out_if import bqf_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int CH_W        = 3
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [CH_W-1:0]               out_channel;
  logic                          clipped;

  modport source (output valid, output sample_out, output out_channel, output clipped,
                  input ready);
  modport sink (input valid, input sample_out, input out_channel, input clipped,
                output ready);
endinterface

### rtl/bqf_mul_serial.sv
// Bit-serial Q3.28 multiplier, sign-magnitude, rounds half away from zero.
`include "biquad_iir_filter_multichannel_top_defines.svh"
module bqf_mul_serial import bqf_pkg::*; #(
  parameter int OP_W = DEF_SAMPLE_BITS + DELAY_EXTRA
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [COEF_BITS-1:0] coef_i,
  input  logic signed [OP_W-1:0] op_i,
  output logic                   done_o,
  output logic signed [OP_W+3:0] res_o
);
  localparam int CNT_W = $clog2(COEF_BITS + 1);
  localparam int MAG_W = OP_W + 3;
  localparam int PROD_W = OP_W + COEF_BITS;

  logic                  busy_q, done_q, neg_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [COEF_BITS-1:0]  mc_q, lo_q;
  logic [OP_W-1:0]       mv_q, acc_q;
  logic signed [OP_W+3:0] res_q;

  logic [COEF_BITS-1:0]  mc_in;
  logic [OP_W-1:0]       mv_in;
  logic [OP_W:0]         sum;
  logic [PROD_W-1:0]     prod;
  logic [MAG_W-1:0]      mag;
  logic                  last_step;

  always_comb begin
    mc_in = coef_i[COEF_BITS-1] ? (~coef_i + 1'b1) : coef_i;
    mv_in = op_i[OP_W-1] ? (~op_i + 1'b1) : op_i;
    sum   = {1'b0, acc_q} + (mc_q[0] ? {1'b0, mv_q} : '0);
    prod  = {acc_q, lo_q};
    // product bits above the top of mag are zero for any operand pair
    mag   = prod[COEF_FRAC +: MAG_W] + MAG_W'(prod[COEF_FRAC-1]);
    last_step = (cnt_q == CNT_W'(COEF_BITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (last_step) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // one coefficient bit per cycle, LSB first; shifted-out product bits go to lo_q
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q  <= mc_in;
      mv_q  <= mv_in;
      neg_q <= coef_i[COEF_BITS-1] ^ op_i[OP_W-1];
      acc_q <= '0;
      lo_q  <= '0;
    end else if (busy_q && !last_step) begin
      acc_q <= sum[OP_W:1];
      lo_q  <= {sum[0], lo_q[COEF_BITS-1:1]};
      mc_q  <= mc_q >> 1;
    end else if (busy_q) begin
      res_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `BQF_ASSERT(a_start_idle, start_i |-> !busy_q, "multiplier started while busy")
  `BQF_ASSERT_NEXT(a_done_pulse, done_q, !done_q || busy_q, "done held longer than a cycle")
  `BQF_ASSERT(a_cnt_range, busy_q |-> cnt_q <= CNT_W'(COEF_BITS), "step counter overran")

endmodule

### rtl/bqf_state_mem.sv
// Per-channel delay state memory with valid bits for reset and clear.
`include "biquad_iir_filter_multichannel_top_defines.svh"
module bqf_state_mem import bqf_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int CH_W     = 3,
  parameter int WORD_W   = 2 * (DEF_SAMPLE_BITS + DELAY_EXTRA)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_ctl_t          ctl_i,
  input  logic [CH_W-1:0]   rd_addr_i,
  input  logic [CH_W-1:0]   wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  output logic [WORD_W-1:0] rd_data_o
);
  logic [WORD_W-1:0]   mem_q [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  logic [WORD_W-1:0]   rd_data_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // an entry not written since reset or clear reads as zero
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

  `BQF_ASSERT_NEXT(a_clear_all, ctl_i.clear, valid_q == '0, "clear left a valid entry")
  `BQF_ASSERT_NEXT(a_wr_valid, ctl_i.wr_en && !ctl_i.clear, valid_q[$past(wr_addr_i)],
    "written entry not marked valid")
  `BQF_ASSERT(a_wr_range, ctl_i.wr_en |-> int'(wr_addr_i) < CHANNELS,
    "write beyond channel count")

endmodule

### rtl/biquad_iir_filter_multichannel_top.sv
// Multichannel transposed direct form II biquad, bit-serial multipliers.
// Input is ready only in idle: a filter item runs two dependent passes of the
// bit-serial multipliers (feedforward, then feedback) and waits for the output
// slot before the next item is taken; clear and out-of-range items are taken
// in idle without leaving it. Reset: b0 = 1.0, other coefficients 0,
// all delay lines read as zero through per-channel valid bits, no clearing pass.
`include "biquad_iir_filter_multichannel_top_defines.svh"
module biquad_iir_filter_multichannel_top import bqf_pkg::*; #(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bqf_in_if.sink               in_i,
  bqf_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_BITS-1:0] cfg_data_i
);
  localparam int DB   = SAMPLE_BITS + DELAY_EXTRA;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MR_W = DB + 4;
  localparam int T_W  = DB + 5;
  localparam int N_W  = DB + 6;
  localparam int Y_W  = T_W - DELAY_FRAC;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE = 3'd0;
  localparam logic [ST_W-1:0] S_READ = 3'd1;
  localparam logic [ST_W-1:0] S_MUL1 = 3'd2;
  localparam logic [ST_W-1:0] S_FB   = 3'd3;
  localparam logic [ST_W-1:0] S_MUL2 = 3'd4;
  localparam logic [ST_W-1:0] S_WR   = 3'd5;
  localparam logic [ST_W-1:0] S_OUT  = 3'd6;

  function automatic logic signed [DB-1:0] sat_delay(input logic signed [N_W-1:0] v);
    logic [N_W-DB:0] hi;
    hi = v[N_W-1:DB-1];
    if (&hi || ~|hi) return v[DB-1:0];
    else if (v[N_W-1]) return {1'b1, {(DB-1){1'b0}}};
    else return {1'b0, {(DB-1){1'b1}}};
  endfunction

  logic [ST_W-1:0]              state_q, state_d;
  logic signed [COEF_BITS-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [CH_W-1:0]              ch_q;
  logic signed [DB-1:0]         xs_q;
  logic signed [T_W-1:0]        t_q;
  logic signed [MR_W-1:0]       m1_q, m2_q;
  logic signed [N_W-1:0]        n1_q, n2_q;
  logic [SAMPLE_BITS-1:0]       y_q;
  logic                         clip_q;
  logic                         out_valid_q;
  logic [SAMPLE_BITS-1:0]       out_sample_q;
  logic [CH_W-1:0]              out_ch_q;
  logic                         out_clip_q;

  logic                         in_acc, in_range, load_out, phase2;
  logic                         start0, start12;
  logic                         done0, done1, done2;
  logic signed [MR_W-1:0]       res0, res1, res2;
  logic signed [COEF_BITS-1:0]  coef1, coef2;
  logic signed [DB-1:0]         op12, yd, d1, d2;
  logic signed [T_W-1:0]        t_rnd;
  logic signed [Y_W-1:0]        y_rnd;
  logic [Y_W-SAMPLE_BITS:0]     y_hi;
  logic                         y_ovf;
  logic [2*DB-1:0]              rd_data;
  mem_ctl_t                     mem_ctl;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= COEF_ONE;
      b1_q <= COEF_ZERO;
      b2_q <= COEF_ZERO;
      a1_q <= COEF_ZERO;
      a2_q <= COEF_ZERO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_B0:  b0_q <= cfg_data_i;
        REG_B1:  b1_q <= cfg_data_i;
        REG_B2:  b2_q <= cfg_data_i;
        REG_A1:  a1_q <= cfg_data_i;
        REG_A2:  a2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- datapath combinational ----
  always_comb begin
    in_acc   = in_i.valid && in_i.ready;
    in_range = int'(in_i.channel_index) < CHANNELS;
    load_out = (state_q == S_OUT) && (!out_valid_q || out_o.ready);
    phase2   = (state_q == S_FB);
    start0   = (state_q == S_READ);
    start12  = (state_q == S_READ) || (state_q == S_FB);

    d1 = rd_data[2*DB-1:DB];
    d2 = rd_data[DB-1:0];

    yd    = sat_delay(N_W'(t_q));
    op12  = phase2 ? yd : xs_q;
    coef1 = phase2 ? a1_q : b1_q;
    coef2 = phase2 ? a2_q : b2_q;

    // round to nearest (half up) and drop the delay fraction
    t_rnd = t_q + T_W'(1 << (DELAY_FRAC - 1));
    y_rnd = t_rnd[T_W-1:DELAY_FRAC];
    y_hi  = y_rnd[Y_W-1:SAMPLE_BITS-1];
    y_ovf = !(&y_hi || ~|y_hi);

    mem_ctl.rd_en = (state_q == S_IDLE) && in_acc && (in_i.command == CMD_FILTER) && in_range;
    mem_ctl.clear = (state_q == S_IDLE) && in_acc && (in_i.command == CMD_CLEAR);
    mem_ctl.wr_en = (state_q == S_WR);
  end

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (mem_ctl.rd_en) state_d = S_READ;
      S_READ: state_d = S_MUL1;
      S_MUL1: if (done0) state_d = S_FB;
      S_FB:   state_d = S_MUL2;
      S_MUL2: if (done1) state_d = S_WR;
      S_WR:   state_d = S_OUT;
      S_OUT:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_ctl.rd_en) begin
      ch_q <= in_i.channel_index;
      xs_q <= DB'($signed({in_i.sample_in, {DELAY_FRAC{1'b0}}}));
    end
    if ((state_q == S_MUL1) && done0) begin
      t_q  <= T_W'(res0) + T_W'(d1);
      m1_q <= res1;
      m2_q <= res2;
    end
    if (state_q == S_FB) begin
      clip_q <= y_ovf;
      if (!y_ovf) y_q <= y_rnd[SAMPLE_BITS-1:0];
      else if (y_rnd[Y_W-1]) y_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      else y_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    if ((state_q == S_MUL2) && done1) begin
      n1_q <= N_W'(m1_q) - N_W'(res1) + N_W'(d2);
      n2_q <= N_W'(m2_q) - N_W'(res2);
    end
    if (load_out) begin
      out_sample_q <= y_q;
      out_ch_q     <= ch_q;
      out_clip_q   <= clip_q;
    end
  end

  // ---- units ----
  bqf_mul_serial #(.OP_W(DB)) u_mul_b0 (
    .clk_i, .rst_ni, .start_i(start0), .coef_i(b0_q), .op_i(xs_q),
    .done_o(done0), .res_o(res0)
  );

  bqf_mul_serial #(.OP_W(DB)) u_mul_1 (
    .clk_i, .rst_ni, .start_i(start12), .coef_i(coef1), .op_i(op12),
    .done_o(done1), .res_o(res1)
  );

  bqf_mul_serial #(.OP_W(DB)) u_mul_2 (
    .clk_i, .rst_ni, .start_i(start12), .coef_i(coef2), .op_i(op12),
    .done_o(done2), .res_o(res2)
  );

  bqf_state_mem #(.CHANNELS(CHANNELS), .CH_W(CH_W), .WORD_W(2 * DB)) u_state (
    .clk_i, .rst_ni, .ctl_i(mem_ctl),
    .rd_addr_i(in_i.channel_index), .wr_addr_i(ch_q),
    .wr_data_i({sat_delay(n1_q), sat_delay(n2_q)}),
    .rd_data_o(rd_data)
  );

  // ---- ports ----
  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.sample_out  = out_sample_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.clipped     = out_clip_q;

  `BQF_ASSERT(a_busy_no_ready, state_q != S_IDLE |-> !in_i.ready, "input ready while busy")
  `BQF_ASSERT(a_mul_aligned, (state_q == S_MUL1) && done0 |-> done1 && done2,
    "feedforward multipliers out of step")
  `BQF_ASSERT_NEXT(a_out_wait, (state_q == S_OUT) && out_valid_q && !out_o.ready,
    state_q == S_OUT, "result dropped while output beat pending")

endmodule
